[hdl/stg_pkg.sv]
// Shared types, constants and the sine table function for the tone generator.
package stg_pkg;

   localparam int PHASE_BITS          = 32;
   localparam int STEP_BITS           = 32;
   localparam int LENGTH_BITS         = 24;
   localparam int FADE_BITS           = 22;
   localparam int GAIN_BITS           = 17;
   localparam int CSR_DATA_BITS       = 32;
   localparam int CSR_ADDR_BITS       = 4;
   localparam int REQ_DATA_BITS       = 8;
   localparam int QUEUE_DEPTH         = 4;

   localparam int COUNT_BITS_DEFAULT     = 24;
   localparam int SINE_ADDR_BITS_DEFAULT = 10;
   localparam int SAMPLE_BITS_DEFAULT    = 16;

   localparam logic [STEP_BITS-1:0]   PHASE_STEP_RESET  = 32'd42852281;
   localparam logic [LENGTH_BITS-1:0] TONE_LENGTH_RESET = 24'd44100;
   localparam logic [FADE_BITS-1:0]   FADE_LENGTH_RESET = 22'd441;
   localparam logic [GAIN_BITS-1:0]   FADE_GAIN_RESET   = 17'd148;
   localparam logic [GAIN_BITS-1:0]   UNITY_GAIN        = 17'h10000;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [1:0] {
      REG_PHASE_STEP  = 2'd0,
      REG_TONE_LENGTH = 2'd1,
      REG_FADE_LENGTH = 2'd2,
      REG_FADE_GAIN   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]   step;
      logic [LENGTH_BITS-1:0] length;
      logic [FADE_BITS-1:0]   fade;
      logic [GAIN_BITS-1:0]   gain;
   } cfg_type;

   typedef struct packed {
      logic                 sign;
      logic                 unity;
      logic [FADE_BITS-1:0] factor;
      logic                 last;
   } env_cmd_type;

   // Unsigned quotient by shift and subtract, one bit per step.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Magnitude of the quarter sine at table entry m, by a Taylor series in Q2.30.
   function automatic logic [63:0] quarter_sine(input int unsigned m, input int addr_bits,
                                                input int sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] amp;
      logic [63:0] dv;
      x    = (64'(m) * HALF_PI_Q30) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      amp  = (64'd1 << (sample_bits - 1)) - 64'd1;
      for (int n = 1; n <= 7; n++) begin
         dv   = 64'((2 * n) * (2 * n + 1));
         term = div_u64((term * x2) >> 30, dv);
         if ((n & 1) != 0) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return (sum * amp + (ONE_Q30 >> 1)) >> 30;
   endfunction

endpackage

[hdl/stg_front.sv]
// Front end: accept tick words, advance index and phase, classify the fade region.
module stg_front #(
   parameter int COUNT_BITS     = stg_pkg::COUNT_BITS_DEFAULT,
   parameter int SINE_ADDR_BITS = stg_pkg::SINE_ADDR_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    restart,
   input  stg_pkg::cfg_type        cfg,
   input  logic                    full,
   output logic                    push,
   output logic [SINE_ADDR_BITS:0] entry,
   output stg_pkg::env_cmd_type    cmd
);
   import stg_pkg::*;

   localparam int CW = ((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS) + 2;
   localparam logic signed [CW-1:0] ONE_S = 1;
   localparam logic [SINE_ADDR_BITS:0] QUARTER = {1'b1, {SINE_ADDR_BITS{1'b0}}};

   logic [COUNT_BITS-1:0]     index_ff, index_in, idx;
   logic [PHASE_BITS-1:0]     phase_ff, phase_in, phase;
   logic signed [CW-1:0]      idx_s, len_s, fade_s, diff_s;
   logic [1:0]                quadrant;
   logic [SINE_ADDR_BITS-1:0] addr;
   logic                      fade_on, fade_in, fade_out, last;

   assign req_ready = !full;
   assign push      = req_valid && !full;

   always_comb begin
      idx      = restart ? '0 : index_ff;
      phase    = restart ? '0 : phase_ff;
      idx_s    = signed'(CW'(idx));
      len_s    = signed'(CW'(cfg.length));
      fade_s   = signed'(CW'(cfg.fade));
      diff_s   = len_s - idx_s;
      fade_on  = cfg.fade != '0;
      fade_in  = fade_on && (idx_s < fade_s);
      fade_out = fade_on && (diff_s < fade_s);
      last     = diff_s <= ONE_S;
      quadrant = phase[PHASE_BITS-1 -: 2];
      addr     = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
      entry    = quadrant[0] ? QUARTER - {1'b0, addr} : {1'b0, addr};
      cmd.sign  = quadrant[1];
      cmd.unity = !(fade_in || fade_out);
      cmd.last  = last;
      if (fade_in) begin
         cmd.factor = idx_s[FADE_BITS-1:0];
      end else if (diff_s[CW-1]) begin
         cmd.factor = '0;
      end else begin
         cmd.factor = diff_s[FADE_BITS-1:0];
      end
   end

   always_comb begin
      index_in = index_ff;
      phase_in = phase_ff;
      if (push) begin
         if (last) begin
            index_in = '0;
            phase_in = '0;
         end else begin
            index_in = idx + COUNT_BITS'(1);
            phase_in = phase + cfg.step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         phase_ff <= '0;
      end else begin
         index_ff <= index_in;
         phase_ff <= phase_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (push && cmd.last) |=> (index_ff == '0 && phase_ff == '0))
      else $error("state not cleared after last word");

endmodule

[hdl/stg_queue.sv]
// Small first-in first-out queue between the front and back ends.
module stg_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = stg_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output logic [DATA_BITS-1:0] rd_data
);
   import stg_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   logic [DATA_BITS-1:0] mem [0:DEPTH-1];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = count_ff == CNT_BITS'(DEPTH);
   assign valid   = count_ff != '0;
   assign rd_data = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count past depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("queue count did not advance on push");

endmodule

[hdl/stg_back.sv]
// Back end: sine table lookup, fade envelope, scaling and the result register.
module stg_back #(
   parameter int SINE_ADDR_BITS = stg_pkg::SINE_ADDR_BITS_DEFAULT,
   parameter int SAMPLE_BITS    = stg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [SINE_ADDR_BITS:0]       entry,
   input  stg_pkg::env_cmd_type          cmd,
   output logic                          pop,
   input  logic [stg_pkg::GAIN_BITS-1:0] gain,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SAMPLE_BITS-1:0]        sample,
   output logic                          last
);
   import stg_pkg::*;

   localparam int MAG_BITS   = SAMPLE_BITS - 1;
   localparam int ROM_DEPTH  = (1 << SINE_ADDR_BITS) + 1;
   localparam int PROD_BITS  = FADE_BITS + GAIN_BITS;
   localparam int SCALE_BITS = MAG_BITS + GAIN_BITS;
   localparam logic [SCALE_BITS-1:0] ROUND_HALF = SCALE_BITS'(32768);

   typedef logic [MAG_BITS-1:0] rom_type [0:ROM_DEPTH-1];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int m = 0; m < ROM_DEPTH; m++) begin
         rom[m] = MAG_BITS'(quarter_sine(m, SINE_ADDR_BITS, SAMPLE_BITS));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic                   en;
   logic                   s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [MAG_BITS-1:0]    mag1_ff, mag2_in;
   logic [PROD_BITS-1:0]   prod1_ff, prod1_in;
   env_cmd_type            cmd1_ff;
   logic                   sign2_ff, last2_ff;
   logic [GAIN_BITS-1:0]   env_in;
   logic [SCALE_BITS-1:0]  scaled2_ff, scaled2_in, rounded;
   logic [MAG_BITS-1:0]    mag_out;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   last_ff;

   assign en        = !out_valid_ff || rsp_ready;
   assign pop       = en && q_valid;
   assign rsp_valid = out_valid_ff;
   assign sample    = sample_ff;
   assign last      = last_ff;

   always_comb begin
      s1_valid_in  = en ? q_valid : s1_valid_ff;
      s2_valid_in  = en ? s1_valid_ff : s2_valid_ff;
      out_valid_in = en ? s2_valid_ff : out_valid_ff;
      prod1_in     = PROD_BITS'(cmd.factor) * PROD_BITS'(gain);
      mag2_in      = mag1_ff;
      if (cmd1_ff.unity || prod1_ff > PROD_BITS'(UNITY_GAIN)) begin
         env_in = UNITY_GAIN;
      end else begin
         env_in = prod1_ff[GAIN_BITS-1:0];
      end
      scaled2_in = SCALE_BITS'(mag2_in) * SCALE_BITS'(env_in);
      rounded    = scaled2_ff + ROUND_HALF;
      mag_out    = rounded[16 +: MAG_BITS];
      sample_in  = sign2_ff ? SAMPLE_BITS'(0) - {1'b0, mag_out} : {1'b0, mag_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff    <= SINE_ROM[entry];
         prod1_ff   <= prod1_in;
         cmd1_ff    <= cmd;
         scaled2_ff <= scaled2_in;
         sign2_ff   <= cmd1_ff.sign;
         last2_ff   <= cmd1_ff.last;
         sample_ff  <= sample_in;
         last_ff    <= last2_ff;
      end
   end

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> env_in <= UNITY_GAIN)
      else $error("envelope above unity");

   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      (en && s2_valid_ff) |=> out_valid_ff)
      else $error("stage two word lost");

endmodule

[hdl/sine_tone_generator_with_fade_top.sv]
// Top level of the faded sine tone generator: register file and the front, queue and back ends.
// Each accepted req word (bit 0 = restart) yields one signed sample on rsp, with rsp_tlast on
// the final sample of the tone. Sustained rate is one sample per clock while rsp_tready stays
// high; the index and phase update in the front end is the only loop.
// A sample passes to rsp through the queue write, the table read with envelope multiply, the
// scale multiply and the result register, in that order. A four-word queue lets the front
// end take words ahead of a stalled output; req_tready drops only when that queue is full.
// The quarter-wave sine table is a constant ROM of 2^SINE_ADDR_BITS + 1 entries with a
// registered read. Write the csr registers only while no word is in flight.
module sine_tone_generator_with_fade_top #(
   parameter int COUNT_BITS     = stg_pkg::COUNT_BITS_DEFAULT,
   parameter int SINE_ADDR_BITS = stg_pkg::SINE_ADDR_BITS_DEFAULT,
   parameter int SAMPLE_BITS    = stg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stg_pkg::REQ_DATA_BITS-1:0] req_tdata,    // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,    // [SAMPLE_BITS-1:0] sample
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [stg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [stg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [stg_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import stg_pkg::*;

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CMD_BITS   = $bits(env_cmd_type);
   localparam int QDATA_BITS = SINE_ADDR_BITS + 1 + CMD_BITS;

   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [FADE_BITS-1:0]   fade_ff, fade_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic                   csr_write;
   reg_index_type          csr_index;
   cfg_type                cfg;

   logic                    front_push, queue_full, queue_valid, back_pop;
   logic [SINE_ADDR_BITS:0] front_entry, back_entry;
   env_cmd_type             front_cmd, back_cmd;
   logic [QDATA_BITS-1:0]   queue_rd;
   logic [SAMPLE_BITS-1:0]  sample;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      step_in   = step_ff;
      length_in = length_ff;
      fade_in   = fade_ff;
      gain_in   = gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PHASE_STEP:  step_in   = csr_pwdata[STEP_BITS-1:0];
            REG_TONE_LENGTH: length_in = csr_pwdata[LENGTH_BITS-1:0];
            REG_FADE_LENGTH: fade_in   = csr_pwdata[FADE_BITS-1:0];
            REG_FADE_GAIN:   gain_in   = csr_pwdata[GAIN_BITS-1:0];
            default:         step_in   = step_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PHASE_STEP:  csr_prdata = CSR_DATA_BITS'(step_ff);
         REG_TONE_LENGTH: csr_prdata = CSR_DATA_BITS'(length_ff);
         REG_FADE_LENGTH: csr_prdata = CSR_DATA_BITS'(fade_ff);
         REG_FADE_GAIN:   csr_prdata = CSR_DATA_BITS'(gain_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= PHASE_STEP_RESET;
         length_ff <= TONE_LENGTH_RESET;
         fade_ff   <= FADE_LENGTH_RESET;
         gain_ff   <= FADE_GAIN_RESET;
      end else begin
         step_ff   <= step_in;
         length_ff <= length_in;
         fade_ff   <= fade_in;
         gain_ff   <= gain_in;
      end
   end

   assign cfg.step   = step_ff;
   assign cfg.length = length_ff;
   assign cfg.fade   = fade_ff;
   assign cfg.gain   = gain_ff;

   stg_front #(
      .COUNT_BITS     (COUNT_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .restart   (req_tdata[0]),
      .cfg       (cfg),
      .full      (queue_full),
      .push      (front_push),
      .entry     (front_entry),
      .cmd       (front_cmd)
   );

   stg_queue #(
      .DATA_BITS (QDATA_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data ({front_entry, front_cmd}),
      .full    (queue_full),
      .pop     (back_pop),
      .valid   (queue_valid),
      .rd_data (queue_rd)
   );

   assign back_entry = queue_rd[QDATA_BITS-1 -: SINE_ADDR_BITS + 1];
   assign back_cmd   = env_cmd_type'(queue_rd[CMD_BITS-1:0]);

   stg_back #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (queue_valid),
      .entry     (back_entry),
      .cmd       (back_cmd),
      .pop       (back_pop),
      .gain      (gain_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sample    (sample),
      .last      (rsp_tlast)
   );

   assign rsp_tdata = TDATA_BITS'(sample);

endmodule
